// ===== rtl/smvb_pkg.sv =====
// Package: shared types and constants for the skinned vertex bounds unit.
package smvb_pkg;
  localparam logic [2:0] KIND_MATRIX = 3'd0;
  localparam logic [2:0] KIND_WEIGHT = 3'd1;
  localparam logic [2:0] KIND_DELTA  = 3'd2;
  localparam logic [2:0] KIND_VERTEX = 3'd3;
  localparam logic [2:0] KIND_REPORT = 3'd4;

  localparam logic CFG_SKIN_ENABLE = 1'b0;
  localparam logic CFG_JOINT_COUNT = 1'b1;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELTA,
    ST_VTX,
    ST_INFL,
    ST_RD,
    ST_MUL,
    ST_ROWEND,
    ST_WGT,
    ST_FINAL,
    ST_BOX
  } state_t;

  // Operand select for the shared multiplier.
  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
  } mul_op_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'(S32_MAX)) r = S32_MAX;
    else if (v < 64'(S32_MIN)) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction
endpackage

// ===== rtl/smvb_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module smvb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1040
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/smvb_mul.sv =====
// Shared registered 32x32 signed multiplier.
module smvb_mul (
  input  logic                clk,
  input  smvb_pkg::mul_op_t   op,
  output logic signed [63:0]  prod_r
);
  always_ff @(posedge clk) begin
    prod_r <= op.a * op.b;
  end
endmodule

// ===== rtl/skinned_morphed_vertex_bounds_unit.sv =====
// Top level: skinned, morphed vertex bounding box built on one shared multiplier.
// Matrix, weight, report and ignored items never raise busy; a report strobes out_valid in
// the cycle after acceptance. A delta holds busy for three products and one drain. A world
// vertex holds busy for setup, 3 rows of 4 read/multiply pairs plus row close, box update.
// Skinned: setup, check per influence, matrix pass and weighting per used one, box update.
// Receiver cannot stall; synchronous active-low reset clears control, weights, offset, box.
module skinned_morphed_vertex_bounds_unit #(
  parameter int JOINTS        = 64,
  parameter int MORPH_TARGETS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_kind,
  input  logic [6:0]         in_slot,
  input  logic [3:0]         in_element,
  input  logic signed [31:0] in_value_x,
  input  logic signed [31:0] in_value_y,
  input  logic signed [31:0] in_value_z,
  input  logic [31:0]        in_joint_ids,
  input  logic [63:0]        in_joint_weights,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [6:0]         cfg_data,
  output logic               out_valid,
  output logic signed [31:0] out_min_x,
  output logic signed [31:0] out_min_y,
  output logic signed [31:0] out_min_z,
  output logic signed [31:0] out_max_x,
  output logic signed [31:0] out_max_y,
  output logic signed [31:0] out_max_z,
  output logic               out_box_empty
);
  import smvb_pkg::*;

  localparam int MAT_WORDS = (JOINTS + 1) * 16;
  localparam int AW = $clog2(MAT_WORDS);
  localparam int MW = (MORPH_TARGETS > 1) ? $clog2(MORPH_TARGETS) : 1;

  // Configuration registers.
  logic       skin_en_r;
  logic [6:0] joint_count_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skin_en_r     <= 1'b0;
      joint_count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SKIN_ENABLE: skin_en_r     <= cfg_data[0];
        CFG_JOINT_COUNT: joint_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic accept;
  assign accept = start && !busy;

  // Matrix store.
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_rdata;
  assign ram_we    = accept && in_kind == KIND_MATRIX && {1'b0, in_slot} <= 8'(JOINTS);
  assign ram_waddr = AW'({in_slot, in_element});
  smvb_ram #(.WIDTH(32), .DEPTH(MAT_WORDS)) u_mat (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(in_value_x),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // Morph weights.
  logic signed [31:0] mw_r [MORPH_TARGETS];
  logic morph_ok;
  assign morph_ok = in_slot < 7'(MORPH_TARGETS);

  state_t state_r, state_nxt;

  logic signed [31:0] p_r [3];      // morphed position
  logic signed [31:0] moff_r [3];   // running morph offset
  logic signed [31:0] t_r [3];      // transformed position of current matrix
  logic signed [63:0] acc_r;        // row accumulator
  logic signed [63:0] skin_r [3];   // influence blend accumulators
  logic signed [31:0] lo_r [3];
  logic signed [31:0] hi_r [3];
  logic               has_r;
  logic [31:0]        ids_r;
  logic [63:0]        ws_r;
  logic [1:0]         k_r;          // influence number
  logic [1:0]         row_r, col_r;
  logic               any_r;
  logic               world_r;      // current pass uses world matrix
  logic signed [31:0] dw_r;         // delta weight
  logic signed [31:0] dv_r [3];
  logic [1:0]         di_r;         // delta component counter
  logic [7:0]         mat_r;        // matrix number

  mul_op_t            mop;
  logic signed [63:0] prod;
  smvb_mul u_mul (.clk(clk), .op(mop), .prod_r(prod));

  logic [7:0]  cur_id;
  logic [15:0] cur_w;
  logic [7:0]  limit;
  assign cur_id = ids_r[8*k_r +: 8];
  assign cur_w  = ws_r[16*k_r +: 16];
  assign limit  = (8'(joint_count_r) < 8'(JOINTS)) ? 8'(joint_count_r) : 8'(JOINTS);

  logic signed [31:0] f [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (world_r) f[i] = t_r[i];
      else if (any_r) f[i] = sat32(skin_r[i]);
      else f[i] = p_r[i];
    end
  end

  assign ram_raddr = AW'({mat_r, row_r, col_r});

  always_comb begin
    state_nxt = state_r;
    mop.a = ram_rdata;
    mop.b = (col_r == 2'd3) ? '0 : p_r[col_r];
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_kind)
            KIND_DELTA:  if (morph_ok) state_nxt = ST_DELTA;
            KIND_VERTEX: state_nxt = ST_VTX;
            default: ;
          endcase
        end
      end
      ST_DELTA: begin
        // last cycle only drains the z product
        mop.a = (di_r == 2'd3) ? '0 : dv_r[di_r];
        mop.b = dw_r;
        if (di_r == 2'd3) state_nxt = ST_IDLE;
      end
      ST_VTX: state_nxt = world_r ? ST_RD : ST_INFL;
      ST_INFL: begin
        if (cur_w != 16'd0 && cur_id < limit) state_nxt = ST_RD;
        else if (k_r == 2'd3) state_nxt = ST_BOX;
      end
      ST_RD: state_nxt = ST_MUL;
      ST_MUL: begin
        // ram data for (row, col) is valid; multiply, then advance col
        if (col_r == 2'd3) state_nxt = ST_ROWEND;
        else state_nxt = ST_RD;
      end
      ST_ROWEND: begin
        if (row_r == 2'd2) state_nxt = world_r ? ST_BOX : ST_WGT;
        else state_nxt = ST_RD;
      end
      ST_WGT: begin
        mop.a = (col_r == 2'd3) ? '0 : t_r[col_r];
        mop.b = {16'd0, cur_w};
        if (col_r == 2'd3) state_nxt = (k_r == 2'd3) ? ST_BOX : ST_INFL;
      end
      ST_BOX:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  assign busy = state_r != ST_IDLE;

  logic signed [63:0] shp;
  assign shp = prod >>> 16;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MORPH_TARGETS; i++) mw_r[i] <= '0;
      for (int i = 0; i < 3; i++) begin
        moff_r[i] <= '0;
        lo_r[i]   <= S32_MAX;
        hi_r[i]   <= S32_MIN;
      end
      has_r     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            unique case (in_kind)
              KIND_WEIGHT: if (morph_ok) mw_r[in_slot[MW-1:0]] <= in_value_x;
              KIND_DELTA: begin
                dw_r <= mw_r[in_slot[MW-1:0]];
                dv_r[0] <= in_value_x;
                dv_r[1] <= in_value_y;
                dv_r[2] <= in_value_z;
                di_r <= 2'd0;
              end
              KIND_VERTEX: begin
                p_r[0] <= sat32(64'(in_value_x) + 64'(moff_r[0]));
                p_r[1] <= sat32(64'(in_value_y) + 64'(moff_r[1]));
                p_r[2] <= sat32(64'(in_value_z) + 64'(moff_r[2]));
                for (int i = 0; i < 3; i++) begin
                  moff_r[i] <= '0;
                  skin_r[i] <= '0;
                end
                ids_r   <= in_joint_ids;
                ws_r    <= in_joint_weights;
                k_r     <= 2'd0;
                any_r   <= 1'b0;
                world_r <= !skin_en_r;
                mat_r   <= '0;
                row_r   <= 2'd0;
                col_r   <= 2'd0;
                acc_r   <= '0;
              end
              KIND_REPORT: begin
                out_valid     <= 1'b1;
                out_min_x     <= has_r ? lo_r[0] : '0;
                out_min_y     <= has_r ? lo_r[1] : '0;
                out_min_z     <= has_r ? lo_r[2] : '0;
                out_max_x     <= has_r ? hi_r[0] : '0;
                out_max_y     <= has_r ? hi_r[1] : '0;
                out_max_z     <= has_r ? hi_r[2] : '0;
                out_box_empty <= !has_r;
                for (int i = 0; i < 3; i++) begin
                  lo_r[i] <= S32_MAX;
                  hi_r[i] <= S32_MIN;
                end
                has_r <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_DELTA: begin
          // product of the previous component, registered in the multiplier, lands in the next cycle
          di_r <= di_r + 2'd1;
          if (di_r != 2'd0) moff_r[di_r - 2'd1] <= sat32(64'(moff_r[di_r - 2'd1]) + shp);
        end
        ST_INFL: begin
          if (cur_w != 16'd0 && cur_id < limit) begin
            mat_r <= cur_id + 8'd1;
            row_r <= 2'd0;
            col_r <= 2'd0;
            acc_r <= '0;
          end else begin
            k_r <= k_r + 2'd1;
          end
        end
        ST_RD: ;
        ST_MUL: begin
          // column 3 is the translation: add it directly
          if (col_r == 2'd3) acc_r <= acc_r + 64'($signed(ram_rdata));
          col_r <= col_r + 2'd1;
        end
        ST_ROWEND: ;
        ST_WGT: begin
          col_r <= col_r + 2'd1;
          if (col_r != 2'd0) skin_r[col_r - 2'd1] <= skin_r[col_r - 2'd1] + (prod >>> 15);
          if (col_r == 2'd3) begin
            any_r <= 1'b1;
            k_r   <= k_r + 2'd1;
          end
        end
        ST_BOX: begin
          for (int i = 0; i < 3; i++) begin
            if (f[i] < lo_r[i]) lo_r[i] <= f[i];
            if (f[i] > hi_r[i]) hi_r[i] <= f[i];
          end
          has_r <= 1'b1;
        end
        default: ;
      endcase

      // Product of column c arrives while in RD for column c+1.
      if (state_r == ST_RD && col_r != 2'd0) acc_r <= acc_r + shp;
      // Close the row: saturate, advance to the next row.
      if (state_r == ST_ROWEND) begin
        t_r[row_r] <= sat32(acc_r);
        row_r <= row_r + 2'd1;
        col_r <= 2'd0;
        acc_r <= '0;
      end
    end
  end

  // Report strobes only in the cycle after a report was accepted.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept) && $past(in_kind) == KIND_REPORT)
    else $error("report without report item");
  // Box is marked nonempty after each vertex.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_BOX |=> has_r)
    else $error("box not marked after vertex");
  // Busy block never accepts.
  assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !accept)
    else $error("accept while busy");
endmodule
